FILE: rtl/core/brfdr_pkg.sv
// Shared constants and types for the dual-reader byte ring.
package brfdr_pkg;

   localparam int DEPTH       = 64;
   localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = 6;
   localparam int WIDE_W      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam int MAX_RESULTS = 63;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP1  = 3'd1,
      OP_POP2  = 3'd2,
      OP_PEEK  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_PEEK
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic single_load;
      logic peek_issue;
      logic peek_load;
   } cmd_type;

   typedef struct packed {
      logic stream;
      logic out_free;
      logic pend;
      logic left_zero;
   } sts_type;

endpackage

FILE: rtl/core/brfdr_ctrl.sv
// Controller state machine: sequences capture, execute and result delivery.
module brfdr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output brfdr_pkg::cmd_type cmd,
   input  brfdr_pkg::sts_type sts
);
   import brfdr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.stream ? ST_PEEK : ST_DRAIN;
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               cmd.single_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_PEEK: begin
            load           = sts.pend && sts.out_free;
            cmd.peek_load  = load;
            cmd.peek_issue = !sts.left_zero && (!sts.pend || load);
            if (load && sts.left_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/brfdr_dpath.sv
// Datapath: pointers, byte store, peek walker and result register.
module brfdr_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  brfdr_pkg::cmd_type         cmd,
   output brfdr_pkg::sts_type         sts,
   input  logic [2:0]                 req_opcode,
   input  logic [7:0]                 req_data_in,
   input  logic [5:0]                 req_peek_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_ok,
   output logic                       rsp_has_byte,
   output logic [7:0]                 rsp_data_out,
   output logic                       rsp_last,
   output logic [brfdr_pkg::CNT_W-1:0] rsp_count_one,
   output logic [brfdr_pkg::CNT_W-1:0] rsp_count_two,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full,
   output logic                       rsp_is_empty_two
);
   import brfdr_pkg::*;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] from);
      logic [PTR_W:0] s;
      if (w >= from) begin
         s = {1'b0, w} - {1'b0, from};
      end else begin
         s = {1'b0, w} + (PTR_W+1)'(DEPTH) - {1'b0, from};
      end
      return s[PTR_W-1:0];
   endfunction

   logic [7:0]       mem [DEPTH];
   logic [2:0]       op_ff;
   logic [7:0]       data_ff;
   logic [5:0]       offset_ff;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd1_ff, rd1_in;
   logic [PTR_W-1:0] rd2_ff, rd2_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [5:0]       left_ff, left_in;
   logic             pend_ff, pend_in;
   logic             res_ok_ff, res_ok_in;
   logic             res_has_ff, res_has_in;
   logic [7:0]       rd_data_ff;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic             wr_en;
   logic             stream;

   logic             full_w, empty_w, empty2_w;
   logic [PTR_W-1:0] cnt1_w, cnt2_w;
   logic [WIDE_W-1:0] cnt_x, off_x, diff_x, sum_x;

   logic             rsp_valid_ff;
   logic             rsp_ok_ff, rsp_has_ff, rsp_last_ff;
   logic [7:0]       rsp_data_ff;
   logic [CNT_W-1:0] rsp_c1_ff, rsp_c2_ff;
   logic             rsp_e_ff, rsp_f_ff, rsp_e2_ff;
   logic             out_free;

   assign cnt1_w   = ring_dist(wr_ff, rd1_ff);
   assign cnt2_w   = ring_dist(wr_ff, rd2_ff);
   assign empty_w  = (rd1_ff == wr_ff);
   assign empty2_w = (rd2_ff == wr_ff);
   assign full_w   = (ring_next(wr_ff) == rd1_ff);
   assign cnt_x    = WIDE_W'(cnt1_w);
   assign off_x    = WIDE_W'(offset_ff);
   assign diff_x   = cnt_x - off_x;
   assign sum_x    = WIDE_W'(rd1_ff) + off_x;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_in      = wr_ff;
      rd1_in     = rd1_ff;
      rd2_in     = rd2_ff;
      pos_in     = pos_ff;
      left_in    = left_ff;
      res_ok_in  = res_ok_ff;
      res_has_in = res_has_ff;
      rd_en      = 1'b0;
      rd_addr    = pos_ff;
      wr_en      = 1'b0;
      stream     = 1'b0;
      pend_in    = cmd.peek_issue || (pend_ff && !cmd.peek_load);
      if (cmd.exec) begin
         res_ok_in  = 1'b0;
         res_has_in = 1'b0;
         pend_in    = 1'b0;
         unique case (op_ff)
            OP_PUSH: begin
               if (!full_w) begin
                  wr_en     = 1'b1;
                  wr_in     = ring_next(wr_ff);
                  res_ok_in = 1'b1;
               end
            end
            OP_POP1: begin
               if (!empty_w) begin
                  rd_en      = 1'b1;
                  rd_addr    = rd1_ff;
                  rd1_in     = ring_next(rd1_ff);
                  res_ok_in  = 1'b1;
                  res_has_in = 1'b1;
               end
            end
            OP_POP2: begin
               if (!empty2_w) begin
                  rd_en      = 1'b1;
                  rd_addr    = rd2_ff;
                  rd2_in     = ring_next(rd2_ff);
                  res_ok_in  = 1'b1;
                  res_has_in = 1'b1;
               end
            end
            OP_PEEK: begin
               if (!empty_w) begin
                  res_ok_in = 1'b1;
                  if (off_x < cnt_x) begin
                     stream = 1'b1;
                     if (diff_x > WIDE_W'(MAX_RESULTS)) begin
                        left_in = 6'(MAX_RESULTS);
                     end else begin
                        left_in = diff_x[5:0];
                     end
                     if (sum_x >= WIDE_W'(DEPTH)) begin
                        pos_in = PTR_W'(sum_x - WIDE_W'(DEPTH));
                     end else begin
                        pos_in = PTR_W'(sum_x);
                     end
                  end
               end
            end
            OP_CLEAR: begin
               wr_in     = '0;
               rd1_in    = '0;
               rd2_in    = '0;
               res_ok_in = 1'b1;
            end
            default: begin
               res_ok_in = 1'b0;
            end
         endcase
      end else if (cmd.peek_issue) begin
         rd_en   = 1'b1;
         rd_addr = pos_ff;
         pos_in  = ring_next(pos_ff);
         left_in = left_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ff] <= data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_opcode;
         data_ff   <= req_data_in;
         offset_ff <= req_peek_offset;
      end
      pos_ff     <= pos_in;
      res_ok_ff  <= res_ok_in;
      res_has_ff <= res_has_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd1_ff       <= '0;
         rd2_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ff   <= wr_in;
         rd1_ff  <= rd1_in;
         rd2_ff  <= rd2_in;
         left_ff <= left_in;
         pend_ff <= pend_in;
         if (cmd.single_load || cmd.peek_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single_load || cmd.peek_load) begin
         rsp_c1_ff <= CNT_W'(cnt1_w);
         rsp_c2_ff <= CNT_W'(cnt2_w);
         rsp_e_ff  <= empty_w;
         rsp_f_ff  <= full_w;
         rsp_e2_ff <= empty2_w;
      end
      if (cmd.single_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_has_ff  <= res_has_ff;
         rsp_data_ff <= res_has_ff ? rd_data_ff : 8'd0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.peek_load) begin
         rsp_ok_ff   <= 1'b1;
         rsp_has_ff  <= 1'b1;
         rsp_data_ff <= rd_data_ff;
         rsp_last_ff <= (left_ff == 6'd0);
      end
   end

   assign sts.stream    = stream;
   assign sts.out_free  = out_free;
   assign sts.pend      = pend_ff;
   assign sts.left_zero = (left_ff == 6'd0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_has_byte     = rsp_has_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_count_one    = rsp_c1_ff;
   assign rsp_count_two    = rsp_c2_ff;
   assign rsp_is_empty     = rsp_e_ff;
   assign rsp_is_full      = rsp_f_ff;
   assign rsp_is_empty_two = rsp_e2_ff;

`ifndef ASSERT_OFF
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.single_load || cmd.peek_load) |-> out_free)
      else $error("result register overwritten while held");

   a_peek_load_has_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.peek_load |-> pend_ff)
      else $error("peek byte delivered without a pending read");

   a_issue_within_count: assert property (@(posedge clock) disable iff (reset)
      cmd.peek_issue |-> (left_ff != 6'd0))
      else $error("peek read issued past its byte count");

   a_push_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_PUSH && !full_w) |=> (wr_ff == ring_next($past(wr_ff))))
      else $error("accepted push did not advance the write pointer");
`endif

endmodule

FILE: rtl/core/byte_ring_fifo_dual_reader_core.sv
// Top level: dual-reader byte ring, controller plus datapath.
// A request is accepted, executed and then its result loaded into the result register; a
// new request is accepted only after that result, or a peek's last byte, has been loaded.
// A peek streams one byte per cycle while the result register is free; a held result stalls it.
// The store has one write and one registered read port; its contents are not reset.
// Synchronous active-high reset clears the three pointers, the FSM and rsp_valid.
module byte_ring_fifo_dual_reader_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic [7:0]                  req_data_in,
   input  logic [5:0]                  req_peek_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic                        rsp_has_byte,
   output logic [7:0]                  rsp_data_out,
   output logic                        rsp_last,
   output logic [brfdr_pkg::CNT_W-1:0] rsp_count_one,
   output logic [brfdr_pkg::CNT_W-1:0] rsp_count_two,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   output logic                        rsp_is_empty_two
);
   import brfdr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   brfdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   brfdr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_data_in      (req_data_in),
      .req_peek_offset  (req_peek_offset),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_data_out     (rsp_data_out),
      .rsp_last         (rsp_last),
      .rsp_count_one    (rsp_count_one),
      .rsp_count_two    (rsp_count_two),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_is_empty_two (rsp_is_empty_two)
   );

endmodule
